// ===== design/gvt_pkg.sv =====
// Shared types and constants for the grid ray visible-tile walker.
// No dependencies; used by gvt_ctrl, gvt_datapath and grid_ray_visible_tiles.
package gvt_pkg;

    localparam int POS_W     = 21;   // Q5.16 eye coordinate
    localparam int FRAC_W    = 16;
    localparam int DIR_W     = 16;   // Q1.15 direction component
    localparam int CNT_W     = 11;
    localparam int RECIP_W   = 32;   // 2^31 / |c| quotient width
    localparam int F_W       = FRAC_W + 1;
    localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_RAY   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_MUL,
        S_STEP,
        S_READ,
        S_TEST,
        S_FINAL
    } state_t;

    typedef struct packed {
        logic accept_start;
        logic accept_ray;
        logic div_step;
        logic mul_load;
        logic do_step;
        logic rd;
        logic commit;
        logic fin_push;
        logic start_push;
    } cmd_t;

    typedef struct packed {
        logic in_bounds;
        logic is_new;
        logic pend_have;
        logic can_push;
    } status_t;

endpackage

// ===== design/gvt_ctrl.sv =====
// Sequencer for start and ray items: divide, multiply, step/read/test loop.
// Depends on gvt_pkg; drives gvt_datapath through cmd_t, watches status_t.
module gvt_ctrl #(
    parameter int MAX_STEPS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             cmd,
    input  gvt_pkg::status_t status,
    output gvt_pkg::cmd_t    ctl
);

    localparam int DIV_CW  = $clog2(gvt_pkg::RECIP_W);
    localparam int STEP_CW = $clog2(MAX_STEPS + 1);

    gvt_pkg::state_t state_reg, state_next;
    logic [DIV_CW-1:0]  div_cnt_reg, div_cnt_next;
    logic [STEP_CW-1:0] step_cnt_reg, step_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gvt_pkg::S_IDLE;
            div_cnt_reg  <= '0;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            div_cnt_reg  <= div_cnt_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        div_cnt_next  = div_cnt_reg;
        step_cnt_next = step_cnt_reg;
        ctl           = '0;
        in_stall      = 1'b1;
        unique case (state_reg)
            gvt_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (cmd == gvt_pkg::CMD_START)
                    begin
                        ctl.accept_start = 1'b1;
                        state_next       = gvt_pkg::S_START;
                    end
                    else
                    begin
                        ctl.accept_ray = 1'b1;
                        div_cnt_next   = '0;
                        step_cnt_next  = '0;
                        state_next     = gvt_pkg::S_DIV;
                    end
                end
            end
            gvt_pkg::S_START:
            begin
                if (status.can_push)
                begin
                    ctl.start_push = 1'b1;
                    state_next     = gvt_pkg::S_IDLE;
                end
            end
            gvt_pkg::S_DIV:
            begin
                ctl.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CW'(gvt_pkg::RECIP_W - 1))
                    state_next = gvt_pkg::S_MUL;
            end
            gvt_pkg::S_MUL:
            begin
                ctl.mul_load = 1'b1;
                state_next   = gvt_pkg::S_STEP;
            end
            gvt_pkg::S_STEP:
            begin
                ctl.do_step   = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                state_next    = gvt_pkg::S_READ;
            end
            gvt_pkg::S_READ:
            begin
                if (status.in_bounds)
                begin
                    ctl.rd     = 1'b1;
                    state_next = gvt_pkg::S_TEST;
                end
                else
                    state_next = gvt_pkg::S_FINAL;
            end
            gvt_pkg::S_TEST:
            begin
                // a new tile flushes the held result first, so it needs the output slot
                if (!status.is_new || !status.pend_have || status.can_push)
                begin
                    ctl.commit = 1'b1;
                    if (step_cnt_reg == STEP_CW'(MAX_STEPS))
                        state_next = gvt_pkg::S_FINAL;
                    else
                        state_next = gvt_pkg::S_STEP;
                end
            end
            gvt_pkg::S_FINAL:
            begin
                if (status.can_push)
                begin
                    ctl.fin_push = 1'b1;
                    state_next   = gvt_pkg::S_IDLE;
                end
            end
            default:
                state_next = gvt_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== design/gvt_datapath.sv =====
// Datapath: origin, reciprocal dividers, boundary distances, cell walk,
// visited bitmap, held result and output register. Depends on gvt_pkg.
module gvt_datapath #(
    parameter int GRID_DIM = 32,
    parameter int IDX_W    = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gvt_pkg::cmd_t                    ctl,
    output gvt_pkg::status_t                 status,
    input  logic [gvt_pkg::POS_W-1:0]        pos_x,
    input  logic [gvt_pkg::POS_W-1:0]        pos_y,
    input  logic signed [gvt_pkg::DIR_W-1:0] dir_u,
    input  logic signed [gvt_pkg::DIR_W-1:0] dir_v,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [IDX_W-1:0]                 tile_index,
    output logic                             tile_valid,
    output logic [gvt_pkg::CNT_W-1:0]        visible_count,
    output logic                             last
);

    localparam int CW     = $clog2(GRID_DIM);
    localparam int CELL_W = CW + 2;
    localparam int LIM_W  = gvt_pkg::FRAC_W + CW + 1;
    localparam int DIST_W = 40;
    localparam int PROD_W = gvt_pkg::F_W + gvt_pkg::RECIP_W;
    localparam int REM_W  = gvt_pkg::DIR_W + 1;
    localparam logic [LIM_W-1:0] POS_LIM = LIM_W'(GRID_DIM * (1 << gvt_pkg::FRAC_W) - 1);

    // origin
    logic [gvt_pkg::POS_W-1:0] org_x_reg, org_y_reg;
    // per-axis setup
    logic                          neg_x_reg, neg_y_reg, zero_x_reg, zero_y_reg;
    logic [gvt_pkg::DIR_W-1:0]     mag_x_reg, mag_y_reg;
    logic [REM_W-1:0]              rem_x_reg, rem_y_reg;
    logic [gvt_pkg::RECIP_W-1:0]   q_x_reg, q_y_reg, num_reg;
    logic [DIST_W-1:0]             dist_x_reg, dist_y_reg;
    logic [CELL_W-1:0]             cx_reg, cy_reg;
    // bitmap
    logic [GRID_DIM-1:0]           map_mem [GRID_DIM];
    logic [GRID_DIM-1:0]           row_ok_reg;
    logic [GRID_DIM-1:0]           rd_row_reg;
    logic                          rd_ok_reg;
    // count, held result, output register
    logic [gvt_pkg::CNT_W-1:0]     count_reg;
    logic                          pend_have_reg;
    logic [IDX_W-1:0]              pend_idx_reg;
    logic [gvt_pkg::CNT_W-1:0]     pend_cnt_reg;
    logic                          out_valid_reg;
    logic [IDX_W-1:0]              out_idx_reg;
    logic                          out_tv_reg, out_last_reg;
    logic [gvt_pkg::CNT_W-1:0]     out_cnt_reg;

    logic [gvt_pkg::POS_W-1:0]     clamp_x, clamp_y;
    logic [CELL_W-1:0]             org_cx, org_cy, sx_cx, sy_cy;
    logic [gvt_pkg::DIR_W-1:0]     mag_u, mag_v;
    logic [REM_W-1:0]              trial_x, trial_y;
    logic [gvt_pkg::F_W-1:0]       f_x, f_y;
    logic [PROD_W-1:0]             prod_x, prod_y;
    logic                          step_x, can_push, is_new, in_bounds;
    logic [IDX_W-1:0]              cur_idx, start_idx;
    logic [gvt_pkg::CNT_W-1:0]     count_inc;
    logic [GRID_DIM-1:0]           cell_bit;

    function automatic logic [gvt_pkg::POS_W-1:0] clamp_pos(
        input logic [gvt_pkg::POS_W-1:0] v
    );
        logic [LIM_W-1:0] w;
        w = LIM_W'(v);
        return (w > POS_LIM) ? gvt_pkg::POS_W'(POS_LIM) : v;
    endfunction

    assign clamp_x = clamp_pos(pos_x);
    assign clamp_y = clamp_pos(pos_y);
    assign org_cx  = CELL_W'(org_x_reg >> gvt_pkg::FRAC_W);
    assign org_cy  = CELL_W'(org_y_reg >> gvt_pkg::FRAC_W);
    assign sx_cx   = CELL_W'(clamp_x >> gvt_pkg::FRAC_W);
    assign sy_cy   = CELL_W'(clamp_y >> gvt_pkg::FRAC_W);
    assign mag_u   = dir_u[gvt_pkg::DIR_W-1] ? (~dir_u + 1'b1) : dir_u;
    assign mag_v   = dir_v[gvt_pkg::DIR_W-1] ? (~dir_v + 1'b1) : dir_v;

    // restoring divide of 2^31 by the magnitude, one quotient bit per cycle per axis
    assign trial_x = {rem_x_reg[REM_W-2:0], num_reg[gvt_pkg::RECIP_W-1]};
    assign trial_y = {rem_y_reg[REM_W-2:0], num_reg[gvt_pkg::RECIP_W-1]};

    // distance to the first edge in the step direction
    assign f_x = neg_x_reg ? gvt_pkg::F_W'(org_x_reg[gvt_pkg::FRAC_W-1:0])
                           : (gvt_pkg::F_W'(1 << gvt_pkg::FRAC_W)
                              - gvt_pkg::F_W'(org_x_reg[gvt_pkg::FRAC_W-1:0]));
    assign f_y = neg_y_reg ? gvt_pkg::F_W'(org_y_reg[gvt_pkg::FRAC_W-1:0])
                           : (gvt_pkg::F_W'(1 << gvt_pkg::FRAC_W)
                              - gvt_pkg::F_W'(org_y_reg[gvt_pkg::FRAC_W-1:0]));
    assign prod_x = PROD_W'(f_x) * PROD_W'(q_x_reg);
    assign prod_y = PROD_W'(f_y) * PROD_W'(q_y_reg);

    // zero component: distance is infinite; y wins ties and infinite-vs-infinite
    assign step_x = !zero_x_reg && (zero_y_reg || (dist_x_reg < dist_y_reg));

    assign in_bounds = (cx_reg < CELL_W'(GRID_DIM)) && (cy_reg < CELL_W'(GRID_DIM));
    assign cell_bit  = GRID_DIM'(1) << cx_reg[CW-1:0];
    assign is_new    = !(rd_ok_reg && rd_row_reg[cx_reg[CW-1:0]]);
    assign cur_idx   = IDX_W'(cx_reg[CW-1:0]) + IDX_W'(cy_reg[CW-1:0]) * IDX_W'(GRID_DIM);
    assign start_idx = cur_idx;
    assign count_inc = (count_reg < gvt_pkg::COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign can_push  = !out_valid_reg || !out_stall;

    assign status.in_bounds = in_bounds;
    assign status.is_new    = is_new;
    assign status.pend_have = pend_have_reg;
    assign status.can_push  = can_push;

    always_ff @(posedge clk)
    begin
        if (ctl.accept_start)
        begin
            cx_reg    <= sx_cx;
            cy_reg    <= sy_cy;
            map_mem[sy_cy[CW-1:0]] <= GRID_DIM'(1) << sx_cx[CW-1:0];
        end
        if (ctl.accept_ray)
        begin
            cx_reg     <= org_cx;
            cy_reg     <= org_cy;
            neg_x_reg  <= dir_u[gvt_pkg::DIR_W-1];
            neg_y_reg  <= dir_v[gvt_pkg::DIR_W-1];
            zero_x_reg <= (mag_u == '0);
            zero_y_reg <= (mag_v == '0);
            mag_x_reg  <= mag_u;
            mag_y_reg  <= mag_v;
            rem_x_reg  <= '0;
            rem_y_reg  <= '0;
            q_x_reg    <= '0;
            q_y_reg    <= '0;
            num_reg    <= gvt_pkg::RECIP_W'(1) << (gvt_pkg::RECIP_W - 1);
        end
        if (ctl.div_step)
        begin
            num_reg <= num_reg << 1;
            if (trial_x >= REM_W'(mag_x_reg))
            begin
                rem_x_reg <= trial_x - REM_W'(mag_x_reg);
                q_x_reg   <= {q_x_reg[gvt_pkg::RECIP_W-2:0], 1'b1};
            end
            else
            begin
                rem_x_reg <= trial_x;
                q_x_reg   <= {q_x_reg[gvt_pkg::RECIP_W-2:0], 1'b0};
            end
            if (trial_y >= REM_W'(mag_y_reg))
            begin
                rem_y_reg <= trial_y - REM_W'(mag_y_reg);
                q_y_reg   <= {q_y_reg[gvt_pkg::RECIP_W-2:0], 1'b1};
            end
            else
            begin
                rem_y_reg <= trial_y;
                q_y_reg   <= {q_y_reg[gvt_pkg::RECIP_W-2:0], 1'b0};
            end
        end
        if (ctl.mul_load)
        begin
            dist_x_reg <= DIST_W'(prod_x >> gvt_pkg::FRAC_W);
            dist_y_reg <= DIST_W'(prod_y >> gvt_pkg::FRAC_W);
        end
        if (ctl.do_step)
        begin
            if (step_x)
            begin
                dist_x_reg <= dist_x_reg + DIST_W'(q_x_reg);
                cx_reg     <= neg_x_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
            end
            else
            begin
                if (!zero_y_reg)
                    dist_y_reg <= dist_y_reg + DIST_W'(q_y_reg);
                cy_reg <= neg_y_reg ? cy_reg - 1'b1 : cy_reg + 1'b1;
            end
        end
        if (ctl.rd)
        begin
            rd_row_reg <= map_mem[cy_reg[CW-1:0]];
            rd_ok_reg  <= row_ok_reg[cy_reg[CW-1:0]];
        end
        if (ctl.commit && is_new)
        begin
            map_mem[cy_reg[CW-1:0]] <= (rd_ok_reg ? rd_row_reg : '0) | cell_bit;
            pend_idx_reg <= cur_idx;
            pend_cnt_reg <= count_inc;
        end
        if (ctl.start_push)
        begin
            out_idx_reg  <= start_idx;
            out_tv_reg   <= 1'b1;
            out_cnt_reg  <= count_reg;
            out_last_reg <= 1'b1;
        end
        else if (ctl.commit && is_new && pend_have_reg)
        begin
            out_idx_reg  <= pend_idx_reg;
            out_tv_reg   <= 1'b1;
            out_cnt_reg  <= pend_cnt_reg;
            out_last_reg <= 1'b0;
        end
        else if (ctl.fin_push)
        begin
            out_idx_reg  <= pend_have_reg ? pend_idx_reg : '0;
            out_tv_reg   <= pend_have_reg;
            out_cnt_reg  <= pend_have_reg ? pend_cnt_reg : count_reg;
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            row_ok_reg    <= '0;
            count_reg     <= '0;
            pend_have_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.accept_start)
            begin
                org_x_reg  <= clamp_x;
                org_y_reg  <= clamp_y;
                row_ok_reg <= GRID_DIM'(1) << sy_cy[CW-1:0];
                count_reg  <= gvt_pkg::CNT_W'(1);
            end
            if (ctl.accept_ray)
                pend_have_reg <= 1'b0;
            if (ctl.commit && is_new)
            begin
                row_ok_reg[cy_reg[CW-1:0]] <= 1'b1;
                count_reg     <= count_inc;
                pend_have_reg <= 1'b1;
            end
            if (ctl.start_push || ctl.fin_push || (ctl.commit && is_new && pend_have_reg))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tile_index    = out_idx_reg;
    assign tile_valid    = out_tv_reg;
    assign visible_count = out_cnt_reg;
    assign last          = out_last_reg;

endmodule

// ===== design/grid_ray_visible_tiles.sv =====
// Ray items: reciprocal divide (one quotient bit per cycle, both axes together), a multiply,
// then per grid step the advance, bitmap row read and test/update states.
// One item is in flight at a time; the bitmap row read/write port sets the step rate.
// Reset (rst_n, async, active low) clears control state, row-valid bits, the count and
// the origin, so a ray before any start walks from tile 0 over an empty bitmap.
module grid_ray_visible_tiles #(
    parameter int GRID_DIM  = 32,
    parameter int MAX_STEPS = 16,
    parameter int IDX_W     = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             cmd,
    input  logic [gvt_pkg::POS_W-1:0]        pos_x,
    input  logic [gvt_pkg::POS_W-1:0]        pos_y,
    input  logic signed [gvt_pkg::DIR_W-1:0] dir_u,
    input  logic signed [gvt_pkg::DIR_W-1:0] dir_v,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [IDX_W-1:0]                 tile_index,
    output logic                             tile_valid,
    output logic [gvt_pkg::CNT_W-1:0]        visible_count,
    output logic                             last
);

    gvt_pkg::cmd_t    ctl;
    gvt_pkg::status_t status;

    gvt_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status),
        .ctl      (ctl)
    );

    gvt_datapath #(
        .GRID_DIM (GRID_DIM),
        .IDX_W    (IDX_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .status        (status),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .dir_u         (dir_u),
        .dir_v         (dir_v),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tile_index    (tile_index),
        .tile_valid    (tile_valid),
        .visible_count (visible_count),
        .last          (last)
    );

endmodule

// ===== bench/grid_ray_visible_tiles_tb.sv =====
// Self-checking testbench for grid_ray_visible_tiles: start and ray items with random gaps
// and output stalls; expected tiles come from an in-bench DDA walker. Depends on gvt_pkg.
`timescale 1ns / 1ps

module grid_ray_visible_tiles_tb;

    localparam int GRID      = 32;
    localparam int STEPS     = 16;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 400;

    typedef struct packed {
        logic                             cmd;
        logic [gvt_pkg::POS_W-1:0]        px;
        logic [gvt_pkg::POS_W-1:0]        py;
        logic signed [gvt_pkg::DIR_W-1:0] du;
        logic signed [gvt_pkg::DIR_W-1:0] dv;
    } ray_item_t;

    typedef struct packed {
        logic [9:0]                idx;
        logic                      tv;
        logic [gvt_pkg::CNT_W-1:0] cnt;
        logic                      lst;
    } tile_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = gvt_pkg::CMD_START;
    logic [gvt_pkg::POS_W-1:0] pos_x = '0;
    logic [gvt_pkg::POS_W-1:0] pos_y = '0;
    logic signed [gvt_pkg::DIR_W-1:0] dir_u = '0;
    logic signed [gvt_pkg::DIR_W-1:0] dir_v = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [9:0] tile_index;
    logic tile_valid;
    logic [gvt_pkg::CNT_W-1:0] visible_count;
    logic last;

    grid_ray_visible_tiles uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .pos_x(pos_x), .pos_y(pos_y), .dir_u(dir_u), .dir_v(dir_v),
        .out_valid(out_valid), .out_stall(out_stall),
        .tile_index(tile_index), .tile_valid(tile_valid),
        .visible_count(visible_count), .last(last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // walker state, matching the block after reset
    logic [GRID-1:0] seen_rows [GRID];
    logic [gvt_pkg::POS_W-1:0] eye_x = '0;
    logic [gvt_pkg::POS_W-1:0] eye_y = '0;
    logic [gvt_pkg::CNT_W-1:0] seen_cnt = '0;

    ray_item_t pending_items [$];
    tile_rec_t expected_tiles [$];
    int  errors = 0;
    int  n_starts = 0, n_rays = 0, n_tiles = 0, n_markers = 0;
    int  wdog = 0;
    bit  hold_sender = 0;

    function automatic logic [gvt_pkg::POS_W-1:0] clamp_eye(logic [gvt_pkg::POS_W-1:0] v);
        logic [gvt_pkg::POS_W-1:0] lim;
        lim = gvt_pkg::POS_W'(GRID * 65536 - 1);
        return (v > lim) ? lim : v;
    endfunction

    function automatic bit mark_tile(int x, int y);
        if (seen_rows[y][x])
            return 0;
        seen_rows[y][x] = 1'b1;
        if (seen_cnt != gvt_pkg::COUNT_MAX)
            seen_cnt++;
        return 1;
    endfunction

    task automatic axis_init(input logic signed [gvt_pkg::DIR_W-1:0] c,
                             input logic [gvt_pkg::POS_W-1:0] p,
                             output int stp, output longint unsigned dlt,
                             output longint unsigned dst);
        longint unsigned frac, mag, f;
        frac = p[gvt_pkg::FRAC_W-1:0];
        mag = (c < 0) ? -int'(c) : int'(c);
        stp = (c < 0) ? -1 : 1;
        f = (c < 0) ? frac : 65536 - frac;
        if (mag == 0)
        begin
            dlt = 0;
            dst = 64'hFFFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            dlt = 64'd2147483648 / mag;
            dst = (f * dlt) >> 16;
        end
    endtask

    task automatic predict_tiles(input ray_item_t it);
        int cx, cy, sx, sy, n;
        longint unsigned ddx, ddy, distx, disty;
        tile_rec_t r;
        n = 0;
        if (it.cmd == gvt_pkg::CMD_START)
        begin
            for (int i = 0; i < GRID; i++)
                seen_rows[i] = '0;
            seen_cnt = 0;
            eye_x = clamp_eye(it.px);
            eye_y = clamp_eye(it.py);
            cx = eye_x >> 16;
            cy = eye_y >> 16;
            void'(mark_tile(cx, cy));
            r = '{idx: 10'(cx + cy * GRID), tv: 1'b1, cnt: seen_cnt, lst: 1'b1};
            expected_tiles.push_back(r);
            return;
        end
        cx = eye_x >> 16;
        cy = eye_y >> 16;
        axis_init(it.du, eye_x, sx, ddx, distx);
        axis_init(it.dv, eye_y, sy, ddy, disty);
        for (int k = 0; k < STEPS; k++)
        begin
            if (distx < disty)
            begin
                distx += ddx;
                cx += sx;
            end
            else
            begin
                if (disty != 64'hFFFF_FFFF_FFFF_FFFF)
                    disty += ddy;
                cy += sy;
            end
            if (cx < 0 || cx >= GRID || cy < 0 || cy >= GRID)
                break;
            if (mark_tile(cx, cy))
            begin
                r = '{idx: 10'(cx + cy * GRID), tv: 1'b1, cnt: seen_cnt, lst: 1'b0};
                expected_tiles.push_back(r);
                n++;
            end
        end
        if (n == 0)
        begin
            r = '{idx: '0, tv: 1'b0, cnt: seen_cnt, lst: 1'b0};
            expected_tiles.push_back(r);
        end
        expected_tiles[$].lst = 1'b1;
    endtask

    // driver
    int in_gap = 0;
    always @(posedge clk)
    begin
        ray_item_t it;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_tiles('{cmd: cmd, px: pos_x, py: pos_y, du: dir_u, dv: dir_v});
                if (cmd == gvt_pkg::CMD_START) n_starts++; else n_rays++;
                in_gap = $urandom_range(0, 3);
            end
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0 || hold_sender || pending_items.size() == 0)
                begin
                    if (in_gap > 0) in_gap--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    it = pending_items.pop_front();
                    in_valid <= 1'b1;
                    cmd <= it.cmd;
                    pos_x <= it.px;
                    pos_y <= it.py;
                    dir_u <= it.du;
                    dir_v <= it.dv;
                end
            end
        end
    end

    // monitor
    int out_gap = 0;
    always @(posedge clk)
    begin
        tile_rec_t e;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                wdog = 0;
            else
                wdog++;
            if (out_valid && !out_stall)
            begin
                if (expected_tiles.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transfer idx=%0d valid=%0d count=%0d last=%0d",
                             $time, tile_index, tile_valid, visible_count, last);
                end
                else
                begin
                    e = expected_tiles.pop_front();
                    if (tile_valid) n_tiles++; else n_markers++;
                    if (tile_index !== e.idx || tile_valid !== e.tv || visible_count !== e.cnt
                        || last !== e.lst)
                    begin
                        errors++;
                        $display("%0t: mismatch exp idx=%0d valid=%0d count=%0d last=%0d",
                                 $time, e.idx, e.tv, e.cnt, e.lst);
                        $display("%0t:          got idx=%0d valid=%0d count=%0d last=%0d",
                                 $time, tile_index, tile_valid, visible_count, last);
                    end
                end
                out_gap = $urandom_range(0, 3);
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
            if (wdog >= WDOG_MAX)
            begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         expected_tiles.size());
                $display("** grid_ray_visible_tiles: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic signed [gvt_pkg::DIR_W-1:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 16'sd0;
            1: return 16'sd32767;
            2: return -16'sd32767;
            3: return $signed(16'($urandom_range(0, 65535)));
            default: return $signed(16'($urandom_range(0, 65534) - 32767));
        endcase
    endfunction

    task automatic add_item(logic c, logic [gvt_pkg::POS_W-1:0] x,
                            logic [gvt_pkg::POS_W-1:0] y,
                            logic signed [gvt_pkg::DIR_W-1:0] u,
                            logic signed [gvt_pkg::DIR_W-1:0] v);
        pending_items.push_back('{cmd: c, px: x, py: y, du: u, dv: v});
    endtask

    initial
    begin
        for (int i = 0; i < GRID; i++)
            seen_rows[i] = '0;
        // ray before any start uses reset origin
        add_item(gvt_pkg::CMD_RAY, '0, '0, 16'sd20000, 16'sd20000);
        add_item(gvt_pkg::CMD_START, '1, '1, 16'sd0, 16'sd0);     // far corner
        add_item(gvt_pkg::CMD_RAY, '0, '0, 16'sd0, 16'sd0);       // both zero: +y, off grid
        add_item(gvt_pkg::CMD_RAY, '0, '0, -16'sd32767, -16'sd32767);
        add_item(gvt_pkg::CMD_START, '0, '0, 16'sd0, 16'sd0);
        add_item(gvt_pkg::CMD_RAY, '0, '0, 16'sd32767, 16'sd0);   // pure x
        add_item(gvt_pkg::CMD_RAY, '0, '0, 16'sd0, 16'sd32767);   // pure y
        add_item(gvt_pkg::CMD_RAY, '0, '0, 16'sd32767, 16'sd32767); // exact ties
        add_item(gvt_pkg::CMD_RAY, '0, '0, 16'sd32767, 16'sd0);   // nothing new: marker
        add_item(gvt_pkg::CMD_RAY, '0, '0, -16'sd1, 16'sd1);
        add_item(gvt_pkg::CMD_START, 21'h10_8000, 21'h0F_FFFF, 16'sd0, 16'sd0);
        add_item(gvt_pkg::CMD_RAY, '0, '0, 16'sd1, -16'sd32767);
        add_item(gvt_pkg::CMD_RAY, '0, '0, 16'sh8000, 16'sd5);
        add_item(gvt_pkg::CMD_RAY, '0, '0, 16'sd12345, -16'sd23456);
        add_item(gvt_pkg::CMD_START, 21'h1F_FFFF, 21'h00_0000, 16'sd0, 16'sd0);
        add_item(gvt_pkg::CMD_RAY, '0, '0, -16'sd30000, 16'sd10000);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                add_item(gvt_pkg::CMD_START,
                         gvt_pkg::POS_W'($urandom_range(0, 21'h1F_FFFF)),
                         gvt_pkg::POS_W'($urandom_range(0, 21'h1F_FFFF)),
                         rand_dir(), rand_dir());
            else
                add_item(gvt_pkg::CMD_RAY,
                         gvt_pkg::POS_W'($urandom_range(0, 21'h1F_FFFF)),
                         gvt_pkg::POS_W'($urandom_range(0, 21'h1F_FFFF)),
                         rand_dir(), rand_dir());
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // let the queue drain partway, then hold the sender until all results are in
        wait (pending_items.size() < N_RANDOM / 2);
        hold_sender = 1;
        wait (expected_tiles.size() == 0 && !in_valid);
        repeat (5) @(posedge clk);
        hold_sender = 0;
        wait (pending_items.size() == 0);
        @(posedge clk);
        wait (!in_valid);
        wait (expected_tiles.size() == 0);
        repeat (100) @(posedge clk);
        $display("Covered %0d start and %0d ray items; %0d new tiles and %0d empty markers.",
                 n_starts, n_rays, n_tiles, n_markers);
        if (errors == 0)
            $display("** grid_ray_visible_tiles: PASSED **");
        else
            $display("** grid_ray_visible_tiles: FAILED **");
        $finish;
    end
endmodule

// ===== grid_ray_visible_tiles.f =====
design/gvt_pkg.sv
design/gvt_ctrl.sv
design/gvt_datapath.sv
design/grid_ray_visible_tiles.sv
bench/grid_ray_visible_tiles_tb.sv
